// ===== hw/rtl/rce_pkg.sv =====
// ----------------------------------------------------------------------------
// rce_pkg
// Shared types and constants for the reflected crc engine: sequencer states,
// register indexes, reset values and the control bundle between the units.
// ----------------------------------------------------------------------------
`default_nettype none

package rce_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned ORDER_W    = 6;
  localparam int unsigned WORD_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_CRC_ORDER      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLYNOMIAL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_VALUE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESULT_XOR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_RESULT = 3'd4;

  localparam logic [ORDER_W-1:0] RST_CRC_ORDER      = 6'd8;
  localparam logic [WORD_W-1:0]  RST_POLYNOMIAL     = 32'h0000_00C6;
  localparam logic [WORD_W-1:0]  RST_INIT_VALUE     = 32'h0000_0055;
  localparam logic [WORD_W-1:0]  RST_RESULT_XOR     = 32'h0000_0000;
  localparam logic               RST_REVERSE_RESULT = 1'b1;

  typedef enum logic {
    RCE_IDLE  = 1'b0,
    RCE_SHIFT = 1'b1
  } rce_state_t;

  typedef struct packed {
    logic load;     // take a new beat into the shift core
    logic step;     // consume one data bit
    logic capture;  // move the finished crc into the output register
  } rce_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/reflected_crc_engine_unit.sv =====
// ----------------------------------------------------------------------------
// reflected_crc_engine_unit
// Configurable lsb-first (reflected) crc engine, one data bit per cycle.
//
//   channel  ports                                   direction
//   in       in_valid/in_ready, start_new/data/bits  beat in
//   out      out_valid/out_ready, out_checksum       beat out
//   cfg      cfg_we, cfg_index, cfg_wdata            register write
//
// A beat accepted from the in channel is shifted into the core one bit per
// step, for data_bits capped at MAX_DATA_BITS bits, then its checksum is
// captured into the output register. The next beat is taken only after that
// capture, once the sequencer is back in idle.
// Capture waits while the output register still holds an untaken checksum.
// Synchronous active-low reset restores the default 8-bit card crc setup.
// ----------------------------------------------------------------------------
`default_nettype none

module reflected_crc_engine_unit #(
  parameter int unsigned MAX_ORDER     = 32,
  parameter int unsigned MAX_DATA_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [rce_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rce_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_start_new,
  input  wire logic [rce_pkg::WORD_W-1:0]      in_data,
  input  wire logic [rce_pkg::ORDER_W-1:0]     in_data_bits,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [rce_pkg::WORD_W-1:0]           out_checksum
);

  localparam logic [rce_pkg::ORDER_W-1:0] MAX_ORD = rce_pkg::ORDER_W'(MAX_ORDER);

  logic [rce_pkg::ORDER_W-1:0] crc_order_r;
  logic [rce_pkg::WORD_W-1:0]  polynomial_r;
  logic [rce_pkg::WORD_W-1:0]  init_value_r;
  logic [rce_pkg::WORD_W-1:0]  result_xor_r;
  logic                        reverse_result_r;

  logic [rce_pkg::ORDER_W-1:0] eff_order;
  logic [MAX_ORDER-1:0]        order_mask;
  logic [MAX_ORDER-1:0]        crc_state;
  logic                        bits_done;
  logic                        out_free;

  rce_pkg::rce_state_t state_r, state_nxt;
  rce_pkg::rce_ctrl_t  ctrl;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_order_r      <= rce_pkg::RST_CRC_ORDER;
      polynomial_r     <= rce_pkg::RST_POLYNOMIAL;
      init_value_r     <= rce_pkg::RST_INIT_VALUE;
      result_xor_r     <= rce_pkg::RST_RESULT_XOR;
      reverse_result_r <= rce_pkg::RST_REVERSE_RESULT;
    end else if (cfg_we) begin
      case (cfg_index)
        rce_pkg::CFG_CRC_ORDER:      crc_order_r      <= cfg_wdata[rce_pkg::ORDER_W-1:0];
        rce_pkg::CFG_POLYNOMIAL:     polynomial_r     <= cfg_wdata;
        rce_pkg::CFG_INIT_VALUE:     init_value_r     <= cfg_wdata;
        rce_pkg::CFG_RESULT_XOR:     result_xor_r     <= cfg_wdata;
        rce_pkg::CFG_REVERSE_RESULT: reverse_result_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // order zero acts as one, anything past the top acts as the top
  assign eff_order  = (crc_order_r == '0)     ? rce_pkg::ORDER_W'(1) :
                      (crc_order_r > MAX_ORD) ? MAX_ORD : crc_order_r;
  assign order_mask = ~({MAX_ORDER{1'b1}} << eff_order);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rce_pkg::RCE_IDLE: begin
        if (in_valid) state_nxt = rce_pkg::RCE_SHIFT;
      end
      rce_pkg::RCE_SHIFT: begin
        if (bits_done && out_free) state_nxt = rce_pkg::RCE_IDLE;
      end
      default: state_nxt = rce_pkg::RCE_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    ctrl.load    = 1'b0;
    ctrl.step    = 1'b0;
    ctrl.capture = 1'b0;
    case (state_r)
      rce_pkg::RCE_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
      end
      rce_pkg::RCE_SHIFT: begin
        ctrl.step    = !bits_done;
        ctrl.capture = bits_done && out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rce_pkg::RCE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  rce_shift_core #(
    .MAX_ORDER     (MAX_ORDER),
    .MAX_DATA_BITS (MAX_DATA_BITS)
  ) u_shift_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .start_new  (in_start_new),
    .data       (in_data),
    .data_bits  (in_data_bits),
    .init_value (init_value_r),
    .polynomial (polynomial_r),
    .order_mask (order_mask),
    .crc_state  (crc_state),
    .bits_done  (bits_done)
  );

  rce_result_stage #(
    .MAX_ORDER (MAX_ORDER)
  ) u_result_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .crc_state      (crc_state),
    .order_mask     (order_mask),
    .eff_order      (eff_order),
    .result_xor     (result_xor_r),
    .reverse_result (reverse_result_r),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_checksum   (out_checksum),
    .out_free       (out_free)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/rce_shift_core.sv =====
// ----------------------------------------------------------------------------
// rce_shift_core
// Bit-serial crc datapath: crc state register, data shift register and the
// remaining bit counter. One data bit, lsb first, per step.
// ----------------------------------------------------------------------------
`default_nettype none

module rce_shift_core #(
  parameter int unsigned MAX_ORDER     = 32,
  parameter int unsigned MAX_DATA_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rce_pkg::rce_ctrl_t           ctrl,
  input  wire logic                         start_new,
  input  wire logic [rce_pkg::WORD_W-1:0]   data,
  input  wire logic [rce_pkg::ORDER_W-1:0]  data_bits,
  input  wire logic [rce_pkg::WORD_W-1:0]   init_value,
  input  wire logic [rce_pkg::WORD_W-1:0]   polynomial,
  input  wire logic [MAX_ORDER-1:0]         order_mask,
  output logic [MAX_ORDER-1:0]              crc_state,
  output logic                              bits_done
);

  localparam int unsigned CNT_W = $clog2(MAX_DATA_BITS + 1);
  localparam logic [rce_pkg::ORDER_W-1:0] MAX_DB = rce_pkg::ORDER_W'(MAX_DATA_BITS);

  logic [MAX_ORDER-1:0]     st_r,   st_nxt;
  logic [MAX_DATA_BITS-1:0] data_r, data_nxt;
  logic [CNT_W-1:0]         cnt_r,  cnt_nxt;
  logic [MAX_ORDER-1:0]     poly_m;
  logic [rce_pkg::ORDER_W-1:0] nbits;
  logic                     fb;

  // polynomial bits above the order never enter the state
  assign poly_m = polynomial[MAX_ORDER-1:0] & order_mask;
  assign nbits  = (data_bits > MAX_DB) ? MAX_DB : data_bits;
  assign fb     = st_r[0] ^ data_r[0];

  always_comb begin
    st_nxt   = st_r;
    data_nxt = data_r;
    cnt_nxt  = cnt_r;
    if (ctrl.load) begin
      st_nxt   = (start_new ? init_value[MAX_ORDER-1:0] : st_r) & order_mask;
      data_nxt = data[MAX_DATA_BITS-1:0];
      cnt_nxt  = CNT_W'(nbits);
    end else if (ctrl.step) begin
      st_nxt   = (st_r >> 1) ^ (fb ? poly_m : '0);
      data_nxt = data_r >> 1;
      cnt_nxt  = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= rce_pkg::RST_INIT_VALUE[MAX_ORDER-1:0];
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign crc_state = st_r;
  assign bits_done = (cnt_r == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/rce_result_stage.sv =====
// ----------------------------------------------------------------------------
// rce_result_stage
// Forms the checksum from the crc state (final xor, mask, optional reversal
// over the order width) and holds it in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rce_result_stage #(
  parameter int unsigned MAX_ORDER = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rce_pkg::rce_ctrl_t           ctrl,
  input  wire logic [MAX_ORDER-1:0]         crc_state,
  input  wire logic [MAX_ORDER-1:0]         order_mask,
  input  wire logic [rce_pkg::ORDER_W-1:0]  eff_order,
  input  wire logic [rce_pkg::WORD_W-1:0]   result_xor,
  input  wire logic                         reverse_result,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic [rce_pkg::WORD_W-1:0]        out_checksum,
  output logic                              out_free
);

  localparam logic [rce_pkg::ORDER_W-1:0] MAX_ORD = rce_pkg::ORDER_W'(MAX_ORDER);

  logic [MAX_ORDER-1:0]         res, res_rev, res_fin;
  logic [rce_pkg::ORDER_W-1:0]  rev_shift;
  logic                         valid_r, valid_nxt;
  logic [rce_pkg::WORD_W-1:0]   checksum_r, checksum_nxt;

  assign res = (crc_state ^ result_xor[MAX_ORDER-1:0]) & order_mask;

  always_comb begin
    for (int i = 0; i < MAX_ORDER; i++) begin
      res_rev[i] = res[MAX_ORDER-1-i];
    end
  end

  // full-width reversal, then drop the unused low bits
  assign rev_shift = MAX_ORD - eff_order;
  assign res_fin   = reverse_result ? (res_rev >> rev_shift) : res;

  assign out_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt    = valid_r;
    checksum_nxt = checksum_r;
    if (ctrl.capture) begin
      valid_nxt    = 1'b1;
      checksum_nxt = rce_pkg::WORD_W'(res_fin);
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    checksum_r <= checksum_nxt;
  end

  assign out_valid    = valid_r;
  assign out_checksum = checksum_r;

endmodule

`default_nettype wire

// ===== sim/tb_reflected_crc_engine_unit.sv =====
// ----------------------------------------------------------------------------
// tb_reflected_crc_engine_unit
// Self-checking bench for the reflected crc engine. A local bit-serial
// predictor tracks the crc state and the register set, queues the checksum
// due for every input beat and compares each output beat against it. The
// run covers directed card crc and register extremes, randomized traffic
// under several idle and stall mixes, and a long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_reflected_crc_engine_unit;

  localparam int unsigned MAX_ORDER     = 32;
  localparam int unsigned MAX_DATA_BITS = 32;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES  = 2 * MAX_DATA_BITS + 8;
  localparam int unsigned CHUNKS        = 6;
  localparam int unsigned CHUNK_BEATS   = 80;

  logic                           clk          = 1'b0;
  logic                           rst_n        = 1'b0;
  logic                           cfg_we       = 1'b0;
  logic [rce_pkg::CFG_IDX_W-1:0]  cfg_index    = rce_pkg::CFG_CRC_ORDER;
  logic [rce_pkg::CFG_DATA_W-1:0] cfg_wdata    = '0;
  logic                           in_valid     = 1'b0;
  logic                           in_ready;
  logic                           in_start_new = 1'b0;
  logic [rce_pkg::WORD_W-1:0]     in_data      = '0;
  logic [rce_pkg::ORDER_W-1:0]    in_data_bits = '0;
  logic                           out_valid;
  logic                           out_ready    = 1'b0;
  logic [rce_pkg::WORD_W-1:0]     out_checksum;

  // predictor copy of the register set and crc state
  logic [rce_pkg::ORDER_W-1:0] crc_order_r;
  logic [rce_pkg::WORD_W-1:0]  poly_r;
  logic [rce_pkg::WORD_W-1:0]  init_r;
  logic [rce_pkg::WORD_W-1:0]  result_xor_r;
  logic                        reverse_r;
  logic [rce_pkg::WORD_W-1:0]  crc_state;

  logic [rce_pkg::WORD_W-1:0]  pending_checksums[$];
  logic [rce_pkg::WORD_W-1:0]  want_sum;
  int unsigned        errors       = 0;
  int unsigned        quiet_cycles = 0;
  int unsigned        send_gap_pct = 0;
  int unsigned        stall_pct    = 0;
  int unsigned        hold_reqs    = 0;
  int unsigned        hold_taken   = 0;
  int unsigned        hold_left    = 0;

  reflected_crc_engine_unit #(
    .MAX_ORDER     (MAX_ORDER),
    .MAX_DATA_BITS (MAX_DATA_BITS)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_start_new (in_start_new),
    .in_data      (in_data),
    .in_data_bits (in_data_bits),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_checksum (out_checksum)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned active_order();
    if (crc_order_r == 0) return 1;
    if (crc_order_r > MAX_ORDER) return MAX_ORDER;
    return 32'(crc_order_r);
  endfunction

  function automatic logic [rce_pkg::WORD_W-1:0] order_bits_mask(int unsigned ord);
    logic [63:0] m;
    m = (64'd1 << ord) - 64'd1;
    return m[rce_pkg::WORD_W-1:0];
  endfunction

  // feeds one beat into the predicted state and returns its checksum
  function automatic logic [rce_pkg::WORD_W-1:0] crc_advance(
      logic start, logic [rce_pkg::WORD_W-1:0] data, logic [rce_pkg::ORDER_W-1:0] nbits);
    int unsigned                ord;
    int unsigned                cnt;
    logic [rce_pkg::WORD_W-1:0] mask;
    logic [rce_pkg::WORD_W-1:0] poly;
    logic [rce_pkg::WORD_W-1:0] st;
    logic [rce_pkg::WORD_W-1:0] res;
    logic [rce_pkg::WORD_W-1:0] rev;
    logic                       fb;
    ord  = active_order();
    mask = order_bits_mask(ord);
    poly = poly_r & mask;
    cnt  = (32'(nbits) > MAX_DATA_BITS) ? MAX_DATA_BITS : 32'(nbits);
    if (start) crc_state = init_r;
    st = crc_state & mask;
    for (int i = 0; i < cnt; i++) begin
      fb = st[0] ^ data[i];
      st = st >> 1;
      if (fb) st = st ^ poly;
    end
    crc_state = st;
    res = (st ^ result_xor_r) & mask;
    if (reverse_r) begin
      rev = '0;
      for (int i = 0; i < ord; i++) rev[ord-1-i] = res[i];
      res = rev;
    end
    return res;
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_taken != hold_reqs) begin
      hold_taken <= hold_reqs;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // predict on input beats, check output beats, watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        pending_checksums.push_back(crc_advance(in_start_new, in_data, in_data_bits));
      if (out_valid && out_ready) begin
        if (pending_checksums.size() == 0) begin
          $error("unexpected checksum beat: actual %08h", out_checksum);
          errors++;
        end else begin
          want_sum = pending_checksums.pop_front();
          if (out_checksum !== want_sum) begin
            $error("checksum mismatch: expected %08h, actual %08h", want_sum, out_checksum);
            errors++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("[reflected_crc_engine_unit] ERROR");
          $finish;
        end
      end
    end
  end

  task automatic send_beat(logic start, logic [rce_pkg::WORD_W-1:0] data,
                           logic [rce_pkg::ORDER_W-1:0] nbits);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_start_new <= start;
    in_data      <= data;
    in_data_bits <= nbits;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_beat();
    int unsigned pick;
    logic [rce_pkg::ORDER_W-1:0] nbits;
    pick = $urandom_range(99);
    if (pick < 50) nbits = 8;
    else if (pick < 85) nbits = rce_pkg::ORDER_W'($urandom_range(1, MAX_DATA_BITS));
    else nbits = rce_pkg::ORDER_W'($urandom_range(0, (1 << rce_pkg::ORDER_W) - 1));
    send_beat($urandom_range(99) < 20, $urandom(), nbits);
  endtask

  // the accepting edge has passed once the first wait is over, so its
  // checksum is already queued when the queue is looked at
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_checksums.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // drives one register write; the predictor follows at once since the block is idle
  task automatic set_reg(logic [rce_pkg::CFG_IDX_W-1:0] idx,
                         logic [rce_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      rce_pkg::CFG_CRC_ORDER:      crc_order_r  = val[rce_pkg::ORDER_W-1:0];
      rce_pkg::CFG_POLYNOMIAL:     poly_r       = val;
      rce_pkg::CFG_INIT_VALUE:     init_r       = val;
      rce_pkg::CFG_RESULT_XOR:     result_xor_r = val;
      rce_pkg::CFG_REVERSE_RESULT: reverse_r    = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic end_cfg();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_all_regs(logic [rce_pkg::ORDER_W-1:0] ord,
                              logic [rce_pkg::WORD_W-1:0] poly,
                              logic [rce_pkg::WORD_W-1:0] init,
                              logic [rce_pkg::WORD_W-1:0] fx, logic rev);
    set_reg(rce_pkg::CFG_CRC_ORDER, rce_pkg::CFG_DATA_W'(ord));
    set_reg(rce_pkg::CFG_POLYNOMIAL, poly);
    set_reg(rce_pkg::CFG_INIT_VALUE, init);
    set_reg(rce_pkg::CFG_RESULT_XOR, fx);
    set_reg(rce_pkg::CFG_REVERSE_RESULT, rce_pkg::CFG_DATA_W'(rev));
    end_cfg();
  endtask

  task automatic rand_config();
    logic [rce_pkg::ORDER_W-1:0] ord;
    case ($urandom_range(9))
      0: ord = 0;
      1: ord = 1;
      2: ord = rce_pkg::ORDER_W'(MAX_ORDER);
      3: ord = rce_pkg::ORDER_W'((1 << rce_pkg::ORDER_W) - 1);
      4: ord = 8;
      default: ord = rce_pkg::ORDER_W'($urandom_range(1, MAX_ORDER));
    endcase
    set_reg(rce_pkg::CFG_CRC_ORDER, rce_pkg::CFG_DATA_W'(ord));
    if ($urandom_range(99) < 70) set_reg(rce_pkg::CFG_POLYNOMIAL, $urandom());
    if ($urandom_range(99) < 50)
      set_reg(rce_pkg::CFG_INIT_VALUE, $urandom_range(1) ? '1 : $urandom());
    if ($urandom_range(99) < 50)
      set_reg(rce_pkg::CFG_RESULT_XOR, $urandom_range(1) ? '0 : $urandom());
    if ($urandom_range(99) < 50) set_reg(rce_pkg::CFG_REVERSE_RESULT, $urandom_range(1));
    if ($urandom_range(99) < 15)
      set_reg(rce_pkg::CFG_IDX_W'($urandom_range(rce_pkg::CFG_REVERSE_RESULT + 1,
                                                 (1 << rce_pkg::CFG_IDX_W) - 1)),
              $urandom());
    end_cfg();
  endtask

  task automatic apply_reset();
    crc_order_r  = rce_pkg::RST_CRC_ORDER;
    poly_r       = rce_pkg::RST_POLYNOMIAL;
    init_r       = rce_pkg::RST_INIT_VALUE;
    result_xor_r = rce_pkg::RST_RESULT_XOR;
    reverse_r    = rce_pkg::RST_REVERSE_RESULT;
    crc_state    = rce_pkg::RST_INIT_VALUE & order_bits_mask(32'(rce_pkg::RST_CRC_ORDER));
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // reset defaults: 8-bit card crc, data and bit count extremes
  task automatic test_card_defaults();
    send_beat(1'b0, 32'h0000_0000, 8);
    send_beat(1'b1, 32'h0000_0000, 8);
    send_beat(1'b0, 32'h0000_00FF, 8);
    send_beat(1'b0, 32'h0000_00A5, 8);
    send_beat(1'b0, 32'hFFFF_FFFF, 0);
    send_beat(1'b0, 32'hFFFF_FFFF, 32);
    send_beat(1'b0, 32'hFFFF_FFFF, 6'd63);
    send_beat(1'b1, 32'h1234_5678, 6'd33);
    send_beat(1'b0, 32'h0000_0001, 1);
    wait_drain();
  endtask

  // order clamps, wide polynomial, reversal off, order change mid-message
  task automatic test_register_extremes();
    set_all_regs(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    send_beat(1'b1, 32'hDEAD_BEEF, 32);
    send_beat(1'b0, 32'h0000_0000, 5);
    wait_drain();
    set_all_regs(6'd63, 32'hEDB8_8320, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_beat(1'b1, 32'h0000_0031, 8);
    send_beat(1'b0, 32'hFFFF_FFFF, 32);
    wait_drain();
    set_all_regs(rce_pkg::ORDER_W'(MAX_ORDER), 32'h8000_0001, 32'h0000_0000,
                 32'hA5A5_5A5A, 1'b1);
    send_beat(1'b1, 32'h8000_0000, 32);
    wait_drain();
    // state carries over, truncated to the new order
    set_reg(rce_pkg::CFG_CRC_ORDER, 5);
    end_cfg();
    send_beat(1'b0, 32'h0000_0003, 4);
    wait_drain();
    // writes past the register list change nothing
    for (int k = rce_pkg::CFG_REVERSE_RESULT + 1; k < (1 << rce_pkg::CFG_IDX_W); k++)
      set_reg(rce_pkg::CFG_IDX_W'(k), '1);
    end_cfg();
    send_beat(1'b0, 32'h0000_0001, 3);
    wait_drain();
    set_all_regs(1, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1'b0);
    send_beat(1'b1, 32'h0000_0000, 1);
    send_beat(1'b0, 32'h0000_0001, 1);
    wait_drain();
  endtask

  task automatic test_random_traffic(int unsigned gap_pct, int unsigned stl_pct);
    send_gap_pct =  gap_pct;
    stall_pct    <= stl_pct;
    for (int c = 0; c < CHUNKS; c++) begin
      rand_config();
      for (int i = 0; i < CHUNK_BEATS; i++) send_random_beat();
      wait_drain();
    end
  endtask

  // receiver holds off while beats keep coming, then the sender waits for all results
  task automatic test_output_backpressure();
    send_gap_pct =  0;
    stall_pct    <= 0;
    rand_config();
    hold_reqs    <= hold_reqs + 1;
    for (int i = 0; i < 30; i++) send_random_beat();
    wait_drain();
    for (int i = 0; i < 10; i++) send_random_beat();
    wait_drain();
  endtask

  initial begin
    apply_reset();
    test_card_defaults();
    test_register_extremes();
    test_random_traffic(0, 0);
    test_random_traffic(52, 0);
    test_random_traffic(0, 52);
    test_random_traffic(29, 29);
    test_output_backpressure();
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_checksums.size() != 0) begin
      $error("checksums never delivered: %0d left", pending_checksums.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[reflected_crc_engine_unit] OK");
    end else begin
      $display("[reflected_crc_engine_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== reflected_crc_engine_unit.f =====
hw/rtl/rce_pkg.sv
hw/rtl/rce_shift_core.sv
hw/rtl/rce_result_stage.sv
hw/rtl/reflected_crc_engine_unit.sv
sim/tb_reflected_crc_engine_unit.sv
